// File: src/bstp_pkg.sv
// ----------------------------------------------------------------------------
// bstp_pkg
// Shared types and constants for the bencode scalar token parser: parse
// phases, token types, error codes, result kinds and character codes.
// ----------------------------------------------------------------------------
package bstp_pkg;

    // Default width of the string length accumulator
    localparam int LENGTH_BITS_DEF = 32;

    // Stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 112;
    localparam int OUT_TUSER_W = 2;
    localparam int CFG_W       = 32;

    // Character codes
    localparam logic [7:0] CH_SLASH = 8'd47;   // one below '0'
    localparam logic [7:0] CH_COLON = 8'd58;   // one above '9', also the separator
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_E     = 8'h65;   // 'e'
    localparam logic [7:0] CH_MINUS = 8'h2d;   // '-'
    localparam logic [7:0] CH_I     = 8'h69;   // 'i'
    localparam logic [7:0] CH_D     = 8'h64;   // 'd'
    localparam logic [7:0] CH_L     = 8'h6c;   // 'l'

    // Parse phase, one-hot
    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_LEN    = 6'b000010,
        PH_PAY    = 6'b000100,
        PH_ISTART = 6'b001000,
        PH_ISIGN  = 6'b010000,
        PH_IDIG   = 6'b100000
    } phase_t;

    // Token types
    localparam logic [2:0] TY_INVALID = 3'd0;
    localparam logic [2:0] TY_STR     = 3'd1;
    localparam logic [2:0] TY_INT     = 3'd2;
    localparam logic [2:0] TY_DIC     = 3'd3;
    localparam logic [2:0] TY_LST     = 3'd4;

    // Error codes
    localparam logic [2:0] ER_NONE  = 3'd0;
    localparam logic [2:0] ER_FIRST = 3'd1;
    localparam logic [2:0] ER_CHAR  = 3'd2;
    localparam logic [2:0] ER_EARLY = 3'd3;
    localparam logic [2:0] ER_OVF   = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_CTRL   = 2'd0;
    localparam logic [1:0] KIND_KEPT   = 2'd1;
    localparam logic [1:0] KIND_BEYOND = 2'd2;

    // Integer magnitude limit (2^63 - 1); one more is allowed when negative
    localparam logic [63:0] INT_POS_MAX = 64'h7fff_ffff_ffff_ffff;

endpackage

// File: src/bencode_scalar_token_parser_unit.sv
// ----------------------------------------------------------------------------
// bencode_scalar_token_parser_unit
// Parses one bencoded scalar token per run of bytes, one result per byte.
// Path: input register, one level of parse logic (shift-add by ten plus compare),
// result register. Throughput: one byte per cycle while m_axis_tready does not stall it.
// Reset: asynchronous, active low; clears all parse state, copy_limit = all ones.
// ----------------------------------------------------------------------------
module bencode_scalar_token_parser_unit #(
    parameter int LENGTH_BITS = bstp_pkg::LENGTH_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration: copy_limit
    input  logic                             cfg_we,
    input  logic [bstp_pkg::CFG_W-1:0]       cfg_wdata,
    // Slave side
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [bstp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic                             s_axis_tlast,   // end_of_buffer
    // Master side
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] data_out, [10:8] token_type, [13:11] error_code,
    // [77:14] int_value, [109:78] str_length, [111:110] zero
    output logic [bstp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [bstp_pkg::OUT_TUSER_W-1:0] m_axis_tuser,   // [1:0] kind
    output logic                             m_axis_tlast    // token_done
);

    import bstp_pkg::*;

    localparam int PROD_W = LENGTH_BITS + 4;

    // Configuration
    logic [CFG_W-1:0]       copy_limit_reg;

    // Input stage
    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_eob_reg;

    // Parse state
    phase_t                 phase_reg, phase_next;
    logic                   marker_skipped_reg, marker_skipped_next;
    logic [LENGTH_BITS-1:0] length_acc_reg, length_acc_next;
    logic [LENGTH_BITS-1:0] remaining_reg, remaining_next;
    logic [31:0]            kept_count_reg, kept_count_next;
    logic [63:0]            magnitude_reg, magnitude_next;
    logic                   negative_reg, negative_next;
    logic [2:0]             current_type_reg, current_type_next;

    // Result stage
    logic                   out_valid_reg;
    logic [1:0]             kind_reg, kind_next;
    logic [7:0]             data_reg, data_next;
    logic [2:0]             type_reg, type_next;
    logic                   done_reg, done_next;
    logic [2:0]             err_reg, err_next;
    logic [63:0]            ival_reg, ival_next;
    logic [31:0]            slen_reg, slen_next;

    // Datapath helpers
    logic                   advance;
    logic                   is_dig;
    logic [3:0]             dig;
    logic [PROD_W-1:0]      len_ext;
    logic [PROD_W-1:0]      len_prod;
    logic                   len_ovf;
    logic [67:0]            mag_ext;
    logic [67:0]            mag_prod;
    logic                   mag_ovf;
    logic                   marker_now;
    logic [63:0]            slen_wide;

    // Handshake: the input register frees up whenever its byte moves on
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Digit decode and times-ten accumulate
    assign is_dig   = (in_byte_reg > CH_SLASH) && (in_byte_reg < CH_COLON);
    assign dig      = in_byte_reg[3:0];
    assign len_ext  = PROD_W'(length_acc_reg);
    assign len_prod = (len_ext << 3) + (len_ext << 1) + PROD_W'(dig);
    assign len_ovf  = len_prod[PROD_W-1 -: 4] != 4'd0;
    assign mag_ext  = {4'd0, magnitude_reg};
    assign mag_prod = (mag_ext << 3) + (mag_ext << 1) + 68'(dig);
    assign mag_ovf  = (mag_prod[67:64] != 4'd0) ||
                      (mag_prod[63] && (!negative_reg || (mag_prod[62:0] != 63'd0)));

    // Parse step
    always_comb
    begin
        phase_next          = phase_reg;
        marker_skipped_next = marker_skipped_reg;
        length_acc_next     = length_acc_reg;
        remaining_next      = remaining_reg;
        kept_count_next     = kept_count_reg;
        magnitude_next      = magnitude_reg;
        negative_next       = negative_reg;
        current_type_next   = current_type_reg;
        kind_next           = KIND_CTRL;
        data_next           = 8'd0;
        done_next           = 1'b0;
        err_next            = ER_NONE;
        ival_next           = 64'd0;
        slen_next           = 32'd0;
        marker_now          = 1'b0;
        slen_wide           = 64'd0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (is_dig)
                begin
                    current_type_next = TY_STR;
                    length_acc_next   = LENGTH_BITS'(dig);
                    phase_next        = PH_LEN;
                end
                else if (in_byte_reg == CH_I)
                begin
                    current_type_next = TY_INT;
                    phase_next        = PH_ISTART;
                end
                else if ((in_byte_reg == CH_D) || (in_byte_reg == CH_L))
                begin
                    current_type_next = (in_byte_reg == CH_D) ? TY_DIC : TY_LST;
                    if (marker_skipped_reg)
                    begin
                        err_next = ER_FIRST;
                    end
                    else
                    begin
                        marker_skipped_next = 1'b1;
                        marker_now          = 1'b1;
                    end
                end
                else
                begin
                    current_type_next = TY_INVALID;
                    err_next          = ER_FIRST;
                end
            end
            PH_LEN:
            begin
                if (is_dig)
                begin
                    if (len_ovf)
                        err_next = ER_OVF;
                    else
                        length_acc_next = len_prod[LENGTH_BITS-1:0];
                end
                else if (in_byte_reg == CH_COLON)
                begin
                    if (length_acc_reg == '0)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        remaining_next  = length_acc_reg;
                        kept_count_next = 32'd0;
                        phase_next      = PH_PAY;
                    end
                end
                else
                begin
                    err_next = ER_CHAR;
                end
            end
            PH_PAY:
            begin
                data_next = in_byte_reg;
                if (kept_count_reg < copy_limit_reg)
                begin
                    kind_next       = KIND_KEPT;
                    kept_count_next = kept_count_reg + 32'd1;
                end
                else
                begin
                    kind_next = KIND_BEYOND;
                end
                remaining_next = remaining_reg - LENGTH_BITS'(1);
                if (remaining_next == '0)
                    done_next = 1'b1;
            end
            PH_ISTART, PH_ISIGN, PH_IDIG:
            begin
                if (is_dig)
                begin
                    if (mag_ovf)
                    begin
                        err_next = ER_OVF;
                    end
                    else
                    begin
                        magnitude_next = mag_prod[63:0];
                        phase_next     = PH_IDIG;
                    end
                end
                else if ((in_byte_reg == CH_MINUS) && (phase_reg == PH_ISTART))
                begin
                    negative_next = 1'b1;
                    phase_next    = PH_ISIGN;
                end
                else if ((in_byte_reg == CH_E) && (phase_reg == PH_IDIG))
                begin
                    done_next = 1'b1;
                    ival_next = negative_reg ? (64'd0 - magnitude_reg) : magnitude_reg;
                end
                else
                begin
                    err_next = ER_CHAR;
                end
            end
            default:
            begin
                current_type_next = TY_INVALID;
                err_next          = ER_FIRST;
            end
        endcase

        // Declared length on string completion, low 32 bits
        if (done_next && (current_type_next == TY_STR))
        begin
            slen_wide = 64'(length_acc_next);
            slen_next = slen_wide[31:0];
        end

        // Buffer ran out mid-token
        if (in_eob_reg && !done_next && (err_next == ER_NONE) &&
            ((phase_next != PH_IDLE) || marker_now))
            err_next = ER_EARLY;

        type_next = current_type_next;

        // Back to idle after completion, error or end of buffer
        if (done_next || (err_next != ER_NONE) || in_eob_reg)
        begin
            phase_next        = PH_IDLE;
            length_acc_next   = '0;
            remaining_next    = '0;
            kept_count_next   = 32'd0;
            magnitude_next    = 64'd0;
            negative_next     = 1'b0;
            current_type_next = TY_INVALID;
        end
        if (in_eob_reg)
            marker_skipped_next = 1'b0;
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            copy_limit_reg <= '1;
        else if (cfg_we)
            copy_limit_reg <= cfg_wdata;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata[7:0];
            in_eob_reg  <= s_axis_tlast;
        end
    end

    // Parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            marker_skipped_reg <= 1'b0;
            length_acc_reg     <= '0;
            remaining_reg      <= '0;
            kept_count_reg     <= 32'd0;
            magnitude_reg      <= 64'd0;
            negative_reg       <= 1'b0;
            current_type_reg   <= TY_INVALID;
        end
        else if (advance)
        begin
            phase_reg          <= phase_next;
            marker_skipped_reg <= marker_skipped_next;
            length_acc_reg     <= length_acc_next;
            remaining_reg      <= remaining_next;
            kept_count_reg     <= kept_count_next;
            magnitude_reg      <= magnitude_next;
            negative_reg       <= negative_next;
            current_type_reg   <= current_type_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            kind_reg <= kind_next;
            data_reg <= data_next;
            type_reg <= type_next;
            done_reg <= done_next;
            err_reg  <= err_next;
            ival_reg <= ival_next;
            slen_reg <= slen_next;
        end
    end

    // Master side
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, slen_reg, ival_reg, err_reg, type_reg, data_reg};
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tlast  = done_reg;

endmodule

// File: tb/sv/bencode_token_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bencode_token_checker
// Watches the configuration port and both stream channels of the bencode
// scalar token parser. Every accepted input byte is run through a local
// byte-by-byte parser to predict its result. Each result transaction is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bencode_token_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bstp_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [bstp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic                             s_axis_tlast,   // end_of_buffer
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] data_out, [10:8] token_type, [13:11] error_code,
    // [77:14] int_value, [109:78] str_length, [111:110] zero
    input  logic [bstp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic [bstp_pkg::OUT_TUSER_W-1:0] m_axis_tuser,   // [1:0] kind
    input  logic                             m_axis_tlast,   // token_done
    output int                               mismatch_count,
    output int                               pending_count,
    output int                               done_tokens,
    output int                               failed_tokens
);

    import bstp_pkg::*;

    localparam logic [63:0] LEN_MAX     = (64'd1 << LENGTH_BITS_DEF) - 64'd1;
    localparam logic [63:0] INT_NEG_MAX = 64'h8000_0000_0000_0000;
    localparam int          REPORT_MAX  = 10;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [2:0]  ttype;
        logic        done;
        logic [2:0]  err;
        logic [63:0] ival;
        logic [31:0] slen;
    } parse_result_t;

    // Local copy of parser state and the copy limit
    phase_t        parse_phase;
    logic          marker_seen;
    logic [63:0]   len_acc;
    logic [63:0]   bytes_left;
    logic [31:0]   kept_bytes;
    logic [63:0]   int_mag;
    logic          int_neg;
    logic [2:0]    tok_type;
    logic [31:0]   copy_limit;

    parse_result_t expected_q[$];
    parse_result_t want;
    parse_result_t got;
    int            mismatches;
    int            result_idx;
    int            n_done;
    int            n_failed;

    function automatic logic is_digit(input logic [7:0] b);
        return (b > CH_SLASH) && (b < CH_COLON);
    endfunction

    // Back to the idle phase; the marker flag is kept
    function automatic void clear_token();
        parse_phase = PH_IDLE;
        len_acc     = '0;
        bytes_left  = '0;
        kept_bytes  = '0;
        int_mag     = '0;
        int_neg     = 1'b0;
        tok_type    = TY_INVALID;
    endfunction

    // Advance the parser by one byte and return the result it gives
    function automatic parse_result_t parse_byte(input logic [7:0] b, input logic eob);
        parse_result_t r;
        logic          marker_now;
        logic [63:0]   d;
        logic [63:0]   lim;
        r          = '0;
        marker_now = 1'b0;
        d          = 64'(b - CH_ZERO);
        case (parse_phase)
            PH_IDLE:
            begin
                if (is_digit(b))
                begin
                    tok_type    = TY_STR;
                    len_acc     = d;
                    parse_phase = PH_LEN;
                end
                else if (b == CH_I)
                begin
                    tok_type    = TY_INT;
                    parse_phase = PH_ISTART;
                end
                else if (b == CH_D || b == CH_L)
                begin
                    tok_type = (b == CH_D) ? TY_DIC : TY_LST;
                    // nesting is not supported: only one marker per buffer
                    if (marker_seen)
                        r.err = ER_FIRST;
                    else
                    begin
                        marker_seen = 1'b1;
                        marker_now  = 1'b1;
                    end
                end
                else
                begin
                    tok_type = TY_INVALID;
                    r.err    = ER_FIRST;
                end
            end
            PH_LEN:
            begin
                if (is_digit(b))
                begin
                    if (len_acc > (LEN_MAX - d) / 64'd10)
                        r.err = ER_OVF;
                    else
                        len_acc = len_acc * 64'd10 + d;
                end
                else if (b == CH_COLON)
                begin
                    if (len_acc == 0)
                        r.done = 1'b1;
                    else
                    begin
                        bytes_left  = len_acc;
                        kept_bytes  = '0;
                        parse_phase = PH_PAY;
                    end
                end
                else
                    r.err = ER_CHAR;
            end
            PH_PAY:
            begin
                r.data = b;
                if (kept_bytes < copy_limit)
                begin
                    r.kind     = KIND_KEPT;
                    kept_bytes = kept_bytes + 32'd1;
                end
                else
                    r.kind = KIND_BEYOND;
                bytes_left = bytes_left - 64'd1;
                if (bytes_left == 0)
                    r.done = 1'b1;
            end
            PH_ISTART, PH_ISIGN, PH_IDIG:
            begin
                if (is_digit(b))
                begin
                    lim = int_neg ? INT_NEG_MAX : INT_POS_MAX;
                    if (int_mag > (lim - d) / 64'd10)
                        r.err = ER_OVF;
                    else
                    begin
                        int_mag     = int_mag * 64'd10 + d;
                        parse_phase = PH_IDIG;
                    end
                end
                else if (b == CH_MINUS && parse_phase == PH_ISTART)
                begin
                    int_neg     = 1'b1;
                    parse_phase = PH_ISIGN;
                end
                else if (b == CH_E && parse_phase == PH_IDIG)
                begin
                    r.done = 1'b1;
                    r.ival = int_neg ? (64'd0 - int_mag) : int_mag;
                end
                else
                    r.err = ER_CHAR;
            end
            default:
            begin
                tok_type = TY_INVALID;
                r.err    = ER_FIRST;
            end
        endcase

        if (r.done && tok_type == TY_STR)
            r.slen = len_acc[31:0];

        // buffer ran out inside a token or just after the marker
        if (eob && !r.done && r.err == ER_NONE && (parse_phase != PH_IDLE || marker_now))
            r.err = ER_EARLY;

        r.ttype = tok_type;
        if (r.done || r.err != ER_NONE || eob)
            clear_token();
        if (eob)
            marker_seen = 1'b0;
        return r;
    endfunction

    // Predict on input transactions, compare on output transactions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            copy_limit  = '1;
            marker_seen = 1'b0;
            clear_token();
            expected_q.delete();
            mismatches  = 0;
            result_idx  = 0;
            n_done      = 0;
            n_failed    = 0;
        end
        else
        begin
            if (cfg_we)
                copy_limit = cfg_wdata;

            if (s_axis_tvalid && s_axis_tready)
            begin
                want = parse_byte(s_axis_tdata, s_axis_tlast);
                expected_q.push_back(want);
                if (want.done)
                    n_done++;
                if (want.err != ER_NONE)
                    n_failed++;
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                got.kind  = m_axis_tuser;
                got.data  = m_axis_tdata[7:0];
                got.ttype = m_axis_tdata[10:8];
                got.done  = m_axis_tlast;
                got.err   = m_axis_tdata[13:11];
                got.ival  = m_axis_tdata[77:14];
                got.slen  = m_axis_tdata[109:78];
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%t result %0d arrived with nothing expected", $time, result_idx);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.kind != want.kind || got.data != want.data ||
                        got.ttype != want.ttype || got.done != want.done ||
                        got.err != want.err || got.ival != want.ival ||
                        got.slen != want.slen || m_axis_tdata[111:110] != 2'b00)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                        begin
                            $display("%t result %0d mismatch", $time, result_idx);
                            $display("  expected kind=%0d data=%02h type=%0d done=%0d err=%0d int=%0d len=%0d",
                                     want.kind, want.data, want.ttype, want.done, want.err,
                                     $signed(want.ival), want.slen);
                            $display("  actual   kind=%0d data=%02h type=%0d done=%0d err=%0d int=%0d len=%0d pad=%0d",
                                     got.kind, got.data, got.ttype, got.done, got.err,
                                     $signed(got.ival), got.slen, m_axis_tdata[111:110]);
                        end
                    end
                end
                result_idx++;
            end
        end
        mismatch_count <= mismatches;
        pending_count  <= expected_q.size();
        done_tokens    <= n_done;
        failed_tokens  <= n_failed;
    end

endmodule

// File: tb/sv/bencode_scalar_token_parser_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bencode_scalar_token_parser_unit_tb
// Drives bencoded buffers into the parser: a directed set of edge cases,
// then random well-formed, broken and noise buffers across several copy
// limits and back-pressure patterns. Checking is left to the checker module;
// this top makes stimulus, runs a stall watchdog and gives the verdict.
// ----------------------------------------------------------------------------
module bencode_scalar_token_parser_unit_tb;

    import bstp_pkg::*;

    localparam int LATENCY        = 2;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_PHASES       = 8;
    localparam int PHASE_BYTES    = 200;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CFG_W-1:0]       cfg_wdata     = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [7:0] byte_in
    logic                   s_axis_tlast  = 1'b0; // end_of_buffer
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // data, type, error, int, length
    logic [OUT_TUSER_W-1:0] m_axis_tuser;         // [1:0] kind
    logic                   m_axis_tlast;         // token_done

    int mismatch_count;
    int pending_count;
    int done_tokens;
    int failed_tokens;

    int          idle_pct   = 0;
    int          stall_pct  = 0;
    int          bytes_sent = 0;
    int          buffers    = 0;
    int          stall_cycles = 0;
    logic [7:0]  buf_q[$];

    always #1 clk = ~clk;

    bencode_scalar_token_parser_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    bencode_token_checker token_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .done_tokens    (done_tokens),
        .failed_tokens  (failed_tokens)
    );

    // Receiver back-pressure
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

    // Watchdog: cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("bencode_scalar_token_parser_unit regression: fail");
            $finish;
        end
    end

    // One byte transaction, with random idle cycles in front
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            buf_q.push_back(s[i]);
    endtask

    // Send the assembled buffer, end_of_buffer on its last byte
    task automatic send_buffer();
        for (int i = 0; i < buf_q.size(); i++)
            send_byte(buf_q[i], i == buf_q.size() - 1);
        buf_q.delete();
        buffers++;
    endtask

    task automatic send_text(input string s);
        push_text(s);
        send_buffer();
    endtask

    // Hold the sender until every result is back, then let the pipe settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_copy_limit(input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic add_string_token();
        int len;
        case ($urandom_range(0, 9))
            0:       len = 0;
            1:       len = $urandom_range(13, 40);
            default: len = $urandom_range(1, 12);
        endcase
        if ($urandom_range(0, 7) == 0)
            push_text("0");
        push_text($sformatf("%0d:", len));
        for (int i = 0; i < len; i++)
            buf_q.push_back(8'($urandom));
    endtask

    task automatic add_int_token();
        logic [63:0] mag;
        case ($urandom_range(0, 9))
            0:       mag = INT_POS_MAX + 64'($urandom_range(0, 2));
            1:       mag = {$urandom, $urandom};
            default: mag = {$urandom, $urandom} >> $urandom_range(4, 63);
        endcase
        push_text("i");
        if ($urandom_range(0, 2) == 0)
            push_text("-");
        if ($urandom_range(0, 7) == 0)
            push_text("00");
        push_text($sformatf("%0d", mag));
        push_text("e");
    endtask

    // Mostly well-formed buffers, some broken, a few pure noise
    task automatic add_random_buffer();
        int n_tok;
        int pos;
        if ($urandom_range(0, 99) < 6)
        begin
            repeat ($urandom_range(1, 6))
                buf_q.push_back(8'($urandom));
        end
        else
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                buf_q.push_back($urandom_range(0, 1) ? CH_D : CH_L);
                if ($urandom_range(0, 5) == 0)
                    buf_q.push_back($urandom_range(0, 1) ? CH_D : CH_L);
            end
            n_tok = $urandom_range(1, 3);
            for (int t = 0; t < n_tok; t++)
            begin
                if ($urandom_range(0, 2) == 0)
                    add_int_token();
                else
                    add_string_token();
            end
            // cut short or corrupt one byte
            if ($urandom_range(0, 9) == 0)
            begin
                pos = $urandom_range(1, buf_q.size());
                while (buf_q.size() > pos)
                    buf_q.delete(buf_q.size() - 1);
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                pos        = $urandom_range(0, buf_q.size() - 1);
                buf_q[pos] = 8'($urandom);
            end
        end
    endtask

    function automatic logic [31:0] limit_for_phase(input int ph);
        case (ph)
            1:       return 32'd0;
            2:       return 32'd2;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'd1;
            5:       return 32'($urandom_range(0, 10));
            6:       return 32'hFFFF_FFFE;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int start;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases at the reset copy limit
        send_text("0:");                               // empty string
        push_text("3:");                               // payload byte extremes
        buf_q.push_back(8'h00);
        buf_q.push_back(8'hFF);
        buf_q.push_back(8'h80);
        send_buffer();
        send_text("007:abcdefg");                      // leading zeros in length
        send_text("i-0ei007e");                        // minus zero, leading zeros
        send_text("i9223372036854775807e");
        send_text("i-9223372036854775808e");
        send_text("i9223372036854775808e");            // integer overflow
        send_text("i-9223372036854775809e");
        send_text("iei-e");                            // bad characters inside integer
        send_text("12x");                              // bad character in length
        send_text("4294967296:");                      // length overflow
        send_text("4294967295");                       // early end in length
        send_text("ld");                               // second marker
        send_text("d");                                // early end just after marker
        send_text("li-5e");
        send_text("5:ab");                             // early end in payload
        buf_q.push_back(CH_COLON);                     // bad first bytes
        buf_q.push_back(8'h00);
        buf_q.push_back(8'hFF);
        send_buffer();
        drain();

        // Random phases: each sets an idling and stall pattern, every one after the first a new copy limit
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 76; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 76; end
                default: begin idle_pct = 9; stall_pct = 9; end
            endcase
            if (ph > 0)
                write_copy_limit(limit_for_phase(ph));
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES)
            begin
                add_random_buffer();
                send_buffer();
            end
            drain();
        end

        $display("sent %0d bytes in %0d buffers over %0d copy-limit settings",
                 bytes_sent, buffers, N_PHASES);
        $display("tokens completed: %0d, tokens ending in error: %0d",
                 done_tokens, failed_tokens);
        if (mismatch_count == 0 && pending_count == 0)
            $display("bencode_scalar_token_parser_unit regression: pass");
        else
            $display("bencode_scalar_token_parser_unit regression: fail");
        $finish;
    end

endmodule
